### sv/edge_coverage_bitmap_unit_assert.svh
// ----------------------------------------------------------------------------
// Edge coverage bitmap unit assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// In synthesis builds the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef EDGE_COVERAGE_BITMAP_UNIT_ASSERT_SVH
`define EDGE_COVERAGE_BITMAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define ECB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checks that a condition never holds outside reset.
`define ECB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define ECB_ASSERT(lbl, prop, msg)
`define ECB_NEVER(lbl, cond, msg)
`endif
`endif

### sv/ecb_pkg.sv
// ----------------------------------------------------------------------------
// Edge coverage bitmap package
// Field widths, command codes, hash shifts and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ecb_pkg;

    // Item field widths.
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 64;
    localparam int ENTRY_W = 16;
    localparam int COUNT_W = 8;

    // Default counter table depth.
    localparam int DEFAULT_ENTRIES = 65536;

    // Location hash shifts.
    localparam int HASH_SHIFT_R = 4;
    localparam int HASH_SHIFT_L = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // capture the incoming item
        logic fetch;     // read the counter table at the captured index
        logic commit;    // write back and load the result register
        logic sweep_wr;  // clear one table entry after reset
    } ecb_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;  // the clearing sweep is at the last entry
    } ecb_stat_t;

endpackage

`default_nettype wire

### sv/ecb_if.sv
// ----------------------------------------------------------------------------
// Edge coverage bitmap channel interfaces
// Valid/ready channels for trace items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecb_trace_if;
    logic                        valid;
    logic                        ready;
    logic [ecb_pkg::CMD_W-1:0]   command;
    logic [ecb_pkg::ADDR_W-1:0]  bb_addr;
    logic [ecb_pkg::ENTRY_W-1:0] entry_index;

    modport source (output valid, command, bb_addr, entry_index, input ready);
    modport sink (input valid, command, bb_addr, entry_index, output ready);
endinterface

interface ecb_result_if;
    logic                        valid;
    logic                        ready;
    logic [ecb_pkg::ENTRY_W-1:0] touched_index;
    logic [ecb_pkg::COUNT_W-1:0] counter_value;

    modport source (output valid, touched_index, counter_value, input ready);
    modport sink (input valid, touched_index, counter_value, output ready);
endinterface

`default_nettype wire

### sv/ecb_datapath.sv
// ----------------------------------------------------------------------------
// Edge coverage bitmap datapath
// Location hash, previous-location register, counter table with registered
// read, clearing sweep counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecb_datapath #(
    parameter int BITMAP_ENTRIES = ecb_pkg::DEFAULT_ENTRIES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ecb_pkg::ecb_ctrl_t          ctrl,
    output ecb_pkg::ecb_stat_t               stat,
    input  wire logic [ecb_pkg::CMD_W-1:0]   command,
    input  wire logic [ecb_pkg::ADDR_W-1:0]  bb_addr,
    input  wire logic [ecb_pkg::ENTRY_W-1:0] entry_index,
    output logic      [ecb_pkg::ENTRY_W-1:0] touched_index,
    output logic      [ecb_pkg::COUNT_W-1:0] counter_value
);
    import ecb_pkg::*;

    localparam int IDX_W = $clog2(BITMAP_ENTRIES);

    logic [CMD_W-1:0]         cmd_reg;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         prev_reg, prev_next;
    logic [IDX_W-1:0]         sweep_reg;
    logic [COUNT_W-1:0]       rd_data_reg;
    logic [ENTRY_W-1:0]       out_index_reg;
    logic [COUNT_W-1:0]       out_value_reg;
    logic [ADDR_W-1:0]        hash_full;
    logic [IDX_W-1:0]         location;
    logic [IDX_W+ENTRY_W-1:0] req_ext;
    logic [IDX_W+ENTRY_W-1:0] idx_ext;
    logic [COUNT_W-1:0]       result_value;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [COUNT_W-1:0]       mem_wdata;
    logic [COUNT_W-1:0]       counts [BITMAP_ENTRIES];

    // Hash the block address into a table location.
    assign hash_full = (bb_addr >> HASH_SHIFT_R) ^ (bb_addr << HASH_SHIFT_L);
    assign location  = hash_full[IDX_W-1:0];

    // Requested index wrapped to the table size.
    assign req_ext = {{IDX_W{1'b0}}, entry_index};

    // Index and previous location for the incoming item.
    always_comb
    begin
        idx_next  = '0;
        prev_next = prev_reg;
        unique case (command)
            CMD_RECORD:
            begin
                idx_next  = location ^ prev_reg;
                prev_next = location >> 1;
            end
            CMD_READ,
            CMD_CLEAR:
            begin
                idx_next = req_ext[IDX_W-1:0];
            end
            CMD_START:
            begin
                prev_next = '0;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Item capture, previous-location state and the clearing sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (ctrl.accept)
            begin
                prev_reg <= prev_next;
            end
            if (ctrl.sweep_wr)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= command;
            idx_reg <= idx_next;
        end
    end

    assign stat.sweep_last = (sweep_reg == {IDX_W{1'b1}});

    // Value reported and written back by the item.
    always_comb
    begin
        unique case (cmd_reg)
            CMD_RECORD: result_value = rd_data_reg + 1'b1;
            CMD_READ:   result_value = rd_data_reg;
            default:    result_value = '0;
        endcase
    end

    // Table write port: the clearing sweep or the item's write-back.
    always_comb
    begin
        if (ctrl.sweep_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = ctrl.commit && ((cmd_reg == CMD_RECORD) || (cmd_reg == CMD_CLEAR));
            mem_waddr = idx_reg;
            mem_wdata = result_value;
        end
    end

    // Counter table with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            counts[mem_waddr] <= mem_wdata;
        end
        if (ctrl.fetch)
        begin
            rd_data_reg <= counts[idx_reg];
        end
    end

    // Result register.
    assign idx_ext = {{ENTRY_W{1'b0}}, idx_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_index_reg <= idx_ext[ENTRY_W-1:0];
            out_value_reg <= result_value;
        end
    end

    assign touched_index = out_index_reg;
    assign counter_value = out_value_reg;

endmodule

`default_nettype wire

### sv/ecb_controller.sv
// ----------------------------------------------------------------------------
// Edge coverage bitmap controller
// Sequences the clearing sweep after reset and the read-modify-write of each
// item, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "edge_coverage_bitmap_unit_assert.svh"

module ecb_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire ecb_pkg::ecb_stat_t stat,
    output ecb_pkg::ecb_ctrl_t      ctrl
);
    import ecb_pkg::*;

    localparam logic [1:0] ST_SWEEP  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_FETCH  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    // The result register can take a new item when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        ctrl          = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                ctrl.sweep_wr = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctrl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ctrl.commit = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        priority if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // At most one command is issued per cycle.
    `ECB_ASSERT(a_one_command, $onehot0({ctrl.accept, ctrl.fetch, ctrl.commit, ctrl.sweep_wr}), "more than one command in a cycle")
    // A result is never loaded over one that the receiver has not taken.
    `ECB_NEVER(a_no_overwrite, ctrl.commit && out_valid_reg && !out_ready, "result overwritten")
    // Only one item is in flight: an accept is followed by a cycle without ready.
    `ECB_ASSERT(a_single_item, ctrl.accept |=> !in_ready, "item accepted while busy")
    // The sweep ends after its last entry and hands over to idle.
    `ECB_ASSERT(a_sweep_end, (ctrl.sweep_wr && stat.sweep_last) |=> (state_reg == ST_IDLE), "sweep did not end")

endmodule

`default_nettype wire

### sv/edge_coverage_bitmap_unit.sv
// ----------------------------------------------------------------------------
// Edge coverage bitmap unit
// Counts hashed control-flow edges of a basic-block trace in a table of
// 8-bit wrapping counters, with read, clear and start-trace commands.
// ----------------------------------------------------------------------------
// Usage:
// The trace channel takes one item per handshake: a command, a block start
// address (used by record) and a table index (used by read and clear).
// The result channel returns exactly one item per trace item, in order: the
// table index touched and the counter value after the command.
// After the accepting edge the item reads the counter table, then writes back
// into the result register. A new item is taken only after the previous one
// has finished this read-modify-write of the counter table through its
// single read and single write port.
// A new item is accepted while the previous result still waits in the
// result register; if the receiver stalls, the next item holds in its
// write-back step until the result register is drained.
// Reset: the previous location clears at once, and the table is cleared by a
// sweep of all BITMAP_ENTRIES entries (65536 by default) during which trace
// ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_coverage_bitmap_unit #(
    parameter int BITMAP_ENTRIES = ecb_pkg::DEFAULT_ENTRIES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ecb_trace_if.sink   trace,
    ecb_result_if.source result
);
    import ecb_pkg::*;

    ecb_ctrl_t ctrl;
    ecb_stat_t stat;

    ecb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trace.valid),
        .in_ready  (trace.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    ecb_datapath #(
        .BITMAP_ENTRIES (BITMAP_ENTRIES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (trace.command),
        .bb_addr       (trace.bb_addr),
        .entry_index   (trace.entry_index),
        .touched_index (result.touched_index),
        .counter_value (result.counter_value)
    );

endmodule

`default_nettype wire

### tb/sv/tb_edge_coverage_bitmap_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Edge coverage bitmap unit testbench
// Drives trace items (record, read, clear, start trace) into the unit and
// checks every result item against a bit-exact model of the counter table
// and the previous-location register kept in a small scoreboard class.
// The sender works in bursts with random gaps, the receiver stalls on its
// own changing pattern and once holds off long enough to back up the unit.
// ----------------------------------------------------------------------------
module tb_edge_coverage_bitmap_unit;

    import ecb_pkg::*;

    localparam int        TABLE_ENTRIES    = DEFAULT_ENTRIES;
    localparam bit [63:0] INDEX_MASK       = TABLE_ENTRIES - 1;
    localparam int        TOTAL_ITEMS      = 1850;
    localparam int        POOL_SIZE        = 24;
    localparam int        HOT_DEPTH        = 32;
    localparam int        LONG_HOLD_CYCLES = 400;
    localparam int        HOLD_AFTER       = 600;
    localparam int        SETTLE_CYCLES    = 8;
    localparam int        TIMEOUT_NS       = 6_000_000;

    // One expected result item.
    typedef struct packed {
        logic [ENTRY_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } edge_result_t;

    // Receiver stall patterns.
    typedef enum int {
        DRAIN_FULL,
        DRAIN_RANDOM,
        DRAIN_SPARSE,
        DRAIN_PERIODIC
    } drain_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the hit-counter table and the previous location,
    // plus the queue of results still owed by the unit.
    // ------------------------------------------------------------------------
    class edge_count_scoreboard;
        bit [COUNT_W-1:0] hit_counts [TABLE_ENTRIES];
        bit [ENTRY_W-1:0] prev_loc;
        edge_result_t     expected_counts [$];
        int errors;
        int n_record;
        int n_read;
        int n_clear;
        int n_start;
        int n_wrap;
        int n_checked;

        function int outstanding();
            return expected_counts.size();
        endfunction

        // Applies an accepted trace item to the mirror and queues its result.
        // Returns the table index that the item touches.
        function bit [ENTRY_W-1:0] note_item(logic [CMD_W-1:0] cmd,
                                              logic [ADDR_W-1:0] addr,
                                              logic [ENTRY_W-1:0] idx);
            bit [ADDR_W-1:0]  mixed;
            bit [ENTRY_W-1:0] loc;
            bit [ENTRY_W-1:0] slot;
            edge_result_t     exp_item;

            slot = '0;
            exp_item = '0;
            if (cmd == CMD_RECORD)
            begin
                // Hash the block address, then count the edge from the
                // previous block and remember this one, halved.
                mixed = ((addr >> HASH_SHIFT_R) ^ (addr << HASH_SHIFT_L)) & INDEX_MASK;
                loc = mixed[ENTRY_W-1:0];
                slot = loc ^ prev_loc;
                hit_counts[slot] = hit_counts[slot] + 1'b1;
                if (hit_counts[slot] == '0)
                    n_wrap++;
                exp_item.index = slot;
                exp_item.count = hit_counts[slot];
                prev_loc = loc >> 1;
                n_record++;
            end
            else if (cmd == CMD_READ)
            begin
                slot = idx & INDEX_MASK;
                exp_item.index = slot;
                exp_item.count = hit_counts[slot];
                n_read++;
            end
            else if (cmd == CMD_CLEAR)
            begin
                slot = idx & INDEX_MASK;
                hit_counts[slot] = '0;
                exp_item.index = slot;
                exp_item.count = '0;
                n_clear++;
            end
            else
            begin
                // Start trace: only the previous location is reset.
                prev_loc = '0;
                n_start++;
            end
            expected_counts.push_back(exp_item);
            return slot;
        endfunction

        // Compares one result item with the oldest expectation.
        function void check_result(logic [ENTRY_W-1:0] touched,
                                   logic [COUNT_W-1:0] value);
            edge_result_t exp_item;

            if (expected_counts.size() == 0)
            begin
                $error("Result with no item outstanding: touched_index %h, counter_value %h",
                       touched, value);
                errors++;
                return;
            end
            exp_item = expected_counts.pop_front();
            n_checked++;
            if (touched !== exp_item.index)
            begin
                $error("touched_index mismatch: expected %h, actual %h",
                       exp_item.index, touched);
                errors++;
            end
            if (value !== exp_item.count)
            begin
                $error("counter_value mismatch: expected %h, actual %h",
                       exp_item.count, value);
                errors++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ecb_trace_if  trace_ch ();
    ecb_result_if result_ch ();

    edge_count_scoreboard sb = new();

    bit [ENTRY_W-1:0] hot_index [$];
    int burst_left     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    bit long_hold_done = 1'b0;

    edge_coverage_bitmap_unit #(
        .BITMAP_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .trace (trace_ch),
        .result(result_ch)
    );

    // Clock.
    always #5 clk = ~clk;

    // Watchdog for a hung run.
    initial
    begin
        #(TIMEOUT_NS);
        $error("Timeout: %0d results still outstanding", sb.outstanding());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_result(result_ch.touched_index, result_ch.counter_value);
            results_seen++;
        end
    end

    // Receiver: changes its stall pattern every so often and holds off
    // once for a long stretch so that the unit backs up its input.
    initial
    begin : result_drain
        drain_mode_t mode;
        int          mode_left;
        int          phase_cnt;

        mode = DRAIN_FULL;
        mode_left = 0;
        phase_cnt = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                continue;
            end
            if (mode_left == 0)
            begin
                mode = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                DRAIN_FULL:   result_ch.ready <= 1'b1;
                DRAIN_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
                DRAIN_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:      result_ch.ready <= (phase_cnt % 3 != 0);
            endcase
        end
    end

    // Offers one trace item and waits for its handshake. Gaps between
    // bursts are inserted here. Returns the index the item touches.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [ENTRY_W-1:0] idx, output bit [ENTRY_W-1:0] touched);
        int gap;

        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(30, 80);
            end
            else
            begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
            end
            repeat (gap)
            begin
                @(negedge clk);
                trace_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        trace_ch.valid       <= 1'b1;
        trace_ch.command     <= cmd;
        trace_ch.bb_addr     <= addr;
        trace_ch.entry_index <= idx;
        do
            @(posedge clk);
        while (!trace_ch.ready);
        touched = sb.note_item(cmd, addr, idx);
        items_sent++;
        if (cmd == CMD_RECORD)
        begin
            hot_index.push_back(touched);
            if (hot_index.size() > HOT_DEPTH)
                void'(hot_index.pop_front());
        end
    endtask

    // Stops offering items until every expected result has arrived.
    task automatic wait_drained();
        @(negedge clk);
        trace_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Picks a recently counted index, so reads and clears hit live entries.
    function automatic bit [ENTRY_W-1:0] pick_hot();
        if (hot_index.size() == 0)
            return ENTRY_W'($urandom);
        return hot_index[$urandom_range(0, hot_index.size() - 1)];
    endfunction

    // Stimulus.
    initial
    begin : stimulus
        bit [ENTRY_W-1:0] t;
        bit [ENTRY_W-1:0] spot;
        bit [ADDR_W-1:0]  block_pool [POOL_SIZE];
        bit [ADDR_W-1:0]  a;
        bit               second_loop;
        int               kind;
        int               run_len;

        trace_ch.valid       = 1'b0;
        trace_ch.command     = CMD_START;
        trace_ch.bb_addr     = '0;
        trace_ch.entry_index = '0;
        second_loop = 1'b0;

        // A pool of basic blocks: half look like code addresses, half are
        // arbitrary 64-bit values.
        foreach (block_pool[i])
        begin
            if (i < POOL_SIZE / 2)
                block_pool[i] = 64'h0000_0000_0040_0000 + {$urandom_range(0, 16'hFFFF), 4'h0};
            else
                block_pool[i] = {$urandom, $urandom};
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, every command, clear and start
        // trace behavior, reads of entries never counted.
        send_item(CMD_START,  64'h0, 16'h0000, t);
        send_item(CMD_READ,   64'h0, 16'h0000, t);
        send_item(CMD_READ,   64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, t);
        send_item(CMD_RECORD, 64'h0, 16'h0000, t);
        send_item(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, t);
        send_item(CMD_RECORD, 64'h0000_0000_0000_0010, 16'h0000, t);
        send_item(CMD_RECORD, 64'h8000_0000_0000_0000, 16'h0000, t);
        send_item(CMD_RECORD, 64'h0000_0000_0000_00FF, 16'h0000, t);
        send_item(CMD_RECORD, 64'h0123_4567_89AB_CDEF, 16'h0000, t);
        send_item(CMD_READ,   64'h0, t, t);
        send_item(CMD_START,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, t);
        send_item(CMD_RECORD, 64'h0123_4567_89AB_CDEF, 16'h0000, t);
        spot = t;
        send_item(CMD_CLEAR,  64'h0, spot, t);
        send_item(CMD_READ,   64'h0, spot, t);
        send_item(CMD_CLEAR,  64'h0, 16'hFFFF, t);
        send_item(CMD_READ,   64'h0, 16'hFFFF, t);
        send_item(CMD_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, t);
        send_item(CMD_RECORD, 64'h5555_5555_5555_5555, 16'hAAAA, t);
        send_item(CMD_START,  64'h0, 16'h0000, t);
        send_item(CMD_START,  64'h0, 16'h0000, t);
        send_item(CMD_CLEAR,  64'h0, 16'h0000, t);
        send_item(CMD_READ,   64'h0, 16'h0000, t);

        wait_drained();

        // A tight loop on one block keeps hitting the same counter,
        // so it wraps past 255.
        repeat (300) send_item(CMD_RECORD, 64'h0, ENTRY_W'($urandom), t);
        send_item(CMD_READ, {$urandom, $urandom}, t, t);

        // Random part: mostly trace runs over the block pool, with reads,
        // clears, restarts and some unstructured items in between.
        while (items_sent < TOTAL_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                if ($urandom_range(0, 1))
                    send_item(CMD_START, {$urandom, $urandom}, ENTRY_W'($urandom), t);
                run_len = $urandom_range(4, 30);
                repeat (run_len)
                begin
                    if ($urandom_range(0, 9) == 0)
                        a = {$urandom, $urandom};
                    else
                        a = block_pool[$urandom_range(0, POOL_SIZE - 1)];
                    send_item(CMD_RECORD, a, ENTRY_W'($urandom), t);
                end
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 6))
                    send_item(CMD_READ, {$urandom, $urandom},
                              ($urandom_range(0, 4) == 0) ? ENTRY_W'($urandom) : pick_hot(), t);
            end
            else if (kind < 80)
            begin
                spot = pick_hot();
                send_item(CMD_CLEAR, {$urandom, $urandom}, spot, t);
                send_item(CMD_RECORD, block_pool[$urandom_range(0, POOL_SIZE - 1)],
                          ENTRY_W'($urandom), t);
                send_item(CMD_READ, {$urandom, $urandom}, spot, t);
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(1, 4))
                    send_item(CMD_W'($urandom), {$urandom, $urandom}, ENTRY_W'($urandom), t);
            end
            else if (kind < 90 && !second_loop)
            begin
                second_loop = 1'b1;
                a = block_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_item(CMD_START, 64'h0, 16'h0000, t);
                repeat ($urandom_range(260, 280))
                    send_item(CMD_RECORD, a, ENTRY_W'($urandom), t);
                send_item(CMD_READ, {$urandom, $urandom}, t, t);
            end
            else
            begin
                send_item(CMD_START, {$urandom, $urandom}, ENTRY_W'($urandom), t);
                send_item(CMD_READ, {$urandom, $urandom}, pick_hot(), t);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            $error("%0d expected results never arrived", sb.outstanding());
            sb.errors++;
        end

        $display("Covered %0d items: %0d record, %0d read, %0d clear, %0d start trace.",
                 items_sent, sb.n_record, sb.n_read, sb.n_clear, sb.n_start);
        $display("Checked %0d results; counters wrapped %0d times; %0d-cycle receiver hold.",
                 sb.n_checked, sb.n_wrap, LONG_HOLD_CYCLES);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
